@@ design/sfe_pkg.sv @@
package sfe_pkg;

    localparam logic [7:0] BYTE_ESC   = 8'hD0;
    localparam logic [7:0] BYTE_START = 8'hD1;
    localparam logic [7:0] BYTE_END   = 8'hD2;
    localparam logic [7:0] BYTE_DELIM = 8'hD3;
    localparam logic [7:0] STUFF_MASK = 8'h7F;
    localparam logic [7:0] CHECK_INV  = 8'hFF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_START    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DATA_ESC = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DATA     = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CHK_ESC  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CHK      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_END      = 3'd5;

    typedef struct packed {
        logic       start;
        logic       last;
        logic [7:0] data;
        logic [7:0] chk;
    } cmd_t;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b >= BYTE_ESC) && (b <= BYTE_DELIM);
    endfunction

    function automatic logic [7:0] stuffed(input logic [7:0] b);
        return needs_esc(b) ? (b & STUFF_MASK) : b;
    endfunction

    function automatic logic [7:0] fold_check(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] t;
        t = (acc ^ b) ^ CHECK_INV;
        t = {t[6:0], t[7]};
        return t + b;
    endfunction

endpackage

@@ design/sfe_if.sv @@
interface sfe_in_if;
    import sfe_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfe_out_if;
    import sfe_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;

    modport source (output valid, output out_byte, output run_last, output frame_done,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input frame_done,
                  output ready);
endinterface

@@ design/sfe_front.sv @@
module sfe_front
    import sfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sfe_in_if.sink      payload,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic       frame_open_reg;
    logic       frame_open_next;
    logic [7:0] check_reg;
    logic [7:0] check_next;
    logic [7:0] check_new;

    assign payload.ready = !q_full;
    assign q_push        = payload.valid && payload.ready;

    always_comb
    begin
        check_new       = fold_check(frame_open_reg ? check_reg : 8'h00, payload.data_byte);
        q_cmd.start     = !frame_open_reg;
        q_cmd.last      = payload.last_byte;
        q_cmd.data      = payload.data_byte;
        q_cmd.chk       = check_new;
        frame_open_next = frame_open_reg;
        check_next      = check_reg;
        if (q_push)
        begin
            frame_open_next = !payload.last_byte;
            check_next      = payload.last_byte ? 8'h00 : check_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            check_reg      <= 8'h00;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            check_reg      <= check_next;
        end
    end

endmodule

@@ design/sfe_queue.sv @@
module sfe_queue
    import sfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

@@ design/sfe_back.sv @@
module sfe_back
    import sfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    sfe_out_if.source   line
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;
    logic              frame_done_reg;
    logic [7:0]        emit_byte;
    logic              emit_final;
    logic              emit_done;
    logic              advance;

    assign line.valid      = out_valid_reg;
    assign line.out_byte   = out_byte_reg;
    assign line.run_last   = run_last_reg;
    assign line.frame_done = frame_done_reg;

    assign advance = head_valid && (!out_valid_reg || line.ready);

    always_comb
    begin
        if (busy_reg)
            step = step_reg;
        else if (head_cmd.start)
            step = STEP_START;
        else
            step = needs_esc(head_cmd.data) ? STEP_DATA_ESC : STEP_DATA;

        emit_byte  = BYTE_ESC;
        emit_final = 1'b0;
        emit_done  = 1'b0;
        step_next  = step;
        unique case (step)
            STEP_START:
            begin
                emit_byte = BYTE_START;
                step_next = needs_esc(head_cmd.data) ? STEP_DATA_ESC : STEP_DATA;
            end
            STEP_DATA_ESC:
            begin
                emit_byte = BYTE_ESC;
                step_next = STEP_DATA;
            end
            STEP_DATA:
            begin
                emit_byte  = stuffed(head_cmd.data);
                emit_final = !head_cmd.last;
                step_next  = needs_esc(head_cmd.chk) ? STEP_CHK_ESC : STEP_CHK;
            end
            STEP_CHK_ESC:
            begin
                emit_byte = BYTE_ESC;
                step_next = STEP_CHK;
            end
            STEP_CHK:
            begin
                emit_byte = stuffed(head_cmd.chk);
                step_next = STEP_END;
            end
            STEP_END:
            begin
                emit_byte  = BYTE_END;
                emit_final = 1'b1;
                emit_done  = 1'b1;
            end
            default:
            begin
                emit_byte  = BYTE_END;
                emit_final = 1'b1;
                emit_done  = 1'b1;
            end
        endcase

        pop       = advance && emit_final;
        busy_next = busy_reg;
        if (advance)
            busy_next = !emit_final;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (line.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= emit_byte;
            run_last_reg   <= emit_final;
            frame_done_reg <= emit_done;
        end
    end

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_done_reg |-> run_last_reg && (out_byte_reg == BYTE_END))
        else $error("end byte not closing the beat group");

    a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> head_valid)
        else $error("sequence running without a queued command");

endmodule

@@ design/stuffed_frame_encoder_with_lrc_core.sv @@
// byte-stuffing frame encoder with running check byte
// payload (sink): one payload beat per frame byte, data_byte plus last_byte;
//   a beat is taken when valid and ready are both high
// line (source): one beat per line byte: out_byte, run_last on the final beat
//   caused by an input beat, frame_done on the closing end byte
// each input beat yields 1 to 6 line beats: start byte on the first byte of a
//   frame, the byte (escaped when in 0xD0..0xD3), and on the last byte the
//   stuffed check byte and the end byte
// an input beat passes through the command queue and then the output register
// the output sequencer emits one line byte per cycle while the line receiver is ready,
//   so an item occupies 1 to 6 line bytes; a 4-entry command queue between the input
//   side and the sequencer lets input beats keep arriving during a burst
// when the line receiver stalls, the output register holds its beat and the
//   queue fills; payload ready drops only when the queue is full
// reset clears the frame flag, the check byte, the queue and the output valid
module stuffed_frame_encoder_with_lrc_core
    import sfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sfe_in_if.sink    payload,
    sfe_out_if.source line
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic head_valid;
    cmd_t head_cmd;

    sfe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    sfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .line       (line)
    );

endmodule
